[sv/http_date_to_epoch_parser_defines.svh]
// ----------------------------------------------------------------------------
// HTTP date parser assertion macros
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HTTP_DATE_TO_EPOCH_PARSER_DEFINES_SVH
`define HTTP_DATE_TO_EPOCH_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HDEP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hdep assertion failed");
`define HDEP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hdep assertion failed");
`else
`define HDEP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define HDEP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[sv/hdep_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP date parser package
// Parse phases, status codes, character codes and calendar tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hdep_pkg;

    localparam int NUMBER_MAX_DEFAULT = 65535;

    typedef enum logic [11:0] {
        PH_WDAY   = 12'b0000_0000_0001,
        PH_COMMA  = 12'b0000_0000_0010,
        PH_MDAY   = 12'b0000_0000_0100,
        PH_MONTH  = 12'b0000_0000_1000,
        PH_YEAR   = 12'b0000_0001_0000,
        PH_HOUR   = 12'b0000_0010_0000,
        PH_COLON1 = 12'b0000_0100_0000,
        PH_MIN    = 12'b0000_1000_0000,
        PH_COLON2 = 12'b0001_0000_0000,
        PH_SEC    = 12'b0010_0000_0000,
        PH_DONE   = 12'b0100_0000_0000,
        PH_ERROR  = 12'b1000_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FORMAT   = 3'd1,
        ST_MONTH    = 3'd2,
        ST_YEAR     = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [23:0] MONTH_NAMES [12] = '{
        24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
        24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
    };

    localparam logic [8:0] DAYS_BEFORE_COMMON [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [8:0] DAYS_BEFORE_LEAP [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    function automatic logic is_ws(input logic [7:0] ch);
        return (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
    endfunction

    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] mon);
        logic [8:0] d;
        d = '0;
        if (mon < 4'd12) begin
            d = leap ? DAYS_BEFORE_LEAP[mon] : DAYS_BEFORE_COMMON[mon];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[sv/http_date_to_epoch_parser.sv]
// ----------------------------------------------------------------------------
// HTTP date to Unix time parser
// Parses an HTTP date one character per request and returns Unix seconds.
// ----------------------------------------------------------------------------
// The slave channel takes one character per request in s_tdata, with s_tlast
// marking the final character; a zero character also ends the string and is
// not parsed itself. Each string yields one result request on the master
// channel: m_tdata holds the signed seconds since 1970, m_tuser the status.
// The character parser updates its registered state with each character
// taken, so a character can be taken in every cycle while s_tready is high.
// The parsed fields enter a five-stage pipeline (fields, year division by a
// constant, leap test, day count, constant products) followed by the output
// register, which forms the sum. One string may end in every cycle while
// s_tready is high.
// Reset empties the pipeline and returns the parser to the weekday token.
// When the receiver stalls, results wait in the pipeline stages; characters
// are still taken until every stage holds a result, and then s_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_date_to_epoch_parser_defines.svh"

module http_date_to_epoch_parser #(
    parameter int NUMBER_MAX = hdep_pkg::NUMBER_MAX_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [45:0] epoch_seconds, [47:46] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    import hdep_pkg::*;

    localparam int ACC_W  = $clog2(NUMBER_MAX + 1);
    localparam int VAL_W  = ACC_W + 1;
    localparam int Q_W    = ACC_W - 6;
    localparam int K_SH   = ACC_W + 7;
    localparam int DAYS_W = ACC_W + 10;
    localparam int SEC_W  = 46;
    localparam logic [K_SH-1:0] RECIP_100 = K_SH'((64'd1 << K_SH) / 64'd100);
    localparam logic [ACC_W+3:0] NUM_LIMIT = (ACC_W + 4)'(NUMBER_MAX);
    localparam logic signed [VAL_W-1:0] EPOCH_YEAR = VAL_W'(1970);

    // Parser state.
    phase_t                    phase_reg, phase_next;
    logic [1:0]                tlen_reg, tlen_next;
    logic [23:0]               mtext_reg, mtext_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic                      neg_reg, neg_next;
    logic                      seen_reg, seen_next;
    logic signed [VAL_W-1:0]   day_reg, day_next;
    logic signed [VAL_W-1:0]   year_reg, year_next;
    logic signed [VAL_W-1:0]   hour_reg, hour_next;
    logic signed [VAL_W-1:0]   min_reg, min_next;
    logic signed [VAL_W-1:0]   sec_reg, sec_next;
    status_t                   err_reg, err_next;

    phase_t                    cons_phase;
    logic [1:0]                cons_tlen;
    logic [23:0]               cons_mtext;
    logic [ACC_W-1:0]          cons_acc;
    logic                      cons_neg;
    logic                      cons_seen;
    logic signed [VAL_W-1:0]   cons_day, cons_year, cons_hour, cons_min, cons_sec;
    status_t                   cons_err;

    status_t                   fin_status;
    logic [3:0]                fin_mon;
    logic signed [VAL_W-1:0]   fin_sec;

    logic in_fire;
    logic is_end;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

    // Pipeline stages.
    logic                      s1_valid_reg;
    status_t                   s1_status_reg;
    logic [3:0]                s1_mon_reg;
    logic [ACC_W-1:0]          s1_year_reg;
    logic signed [VAL_W-1:0]   s1_day_reg, s1_hour_reg, s1_min_reg, s1_sec_reg;

    logic                      s2_valid_reg;
    status_t                   s2_status_reg;
    logic [3:0]                s2_mon_reg;
    logic [ACC_W-1:0]          s2_n_reg;
    logic [Q_W-1:0]            s2_q0_reg;
    logic signed [VAL_W-1:0]   s2_day_reg, s2_hour_reg, s2_min_reg, s2_sec_reg;

    logic                      s3_valid_reg;
    status_t                   s3_status_reg;
    logic [3:0]                s3_mon_reg;
    logic [ACC_W-1:0]          s3_n_reg;
    logic [Q_W-1:0]            s3_q_reg;
    logic                      s3_leap_reg;
    logic signed [VAL_W-1:0]   s3_day_reg, s3_hour_reg, s3_min_reg, s3_sec_reg;

    logic                      s4_valid_reg;
    status_t                   s4_status_reg;
    logic [DAYS_W-1:0]         s4_days_reg;
    logic signed [VAL_W-1:0]   s4_hour_reg, s4_min_reg, s4_sec_reg;

    logic                      s5_valid_reg;
    status_t                   s5_status_reg;
    logic [SEC_W-1:0]          s5_dsec_reg, s5_tsec_reg;

    logic                      out_valid_reg;
    logic [SEC_W-1:0]          out_epoch_reg;
    status_t                   out_status_reg;

    logic [ACC_W-1:0]          n1;
    logic [ACC_W+K_SH-1:0]     prod1;
    logic [ACC_W-1:0]          qx100;
    logic [ACC_W-1:0]          rdiff;
    logic [7:0]                r0, r3;
    logic [Q_W-1:0]            q3;
    logic                      leap3;
    logic [DAYS_W-1:0]         days4;
    logic [SEC_W-1:0]          dsec5, tsec5;

    assign in_fire = s_tvalid && s_tready;
    assign is_end  = (s_tdata == 8'd0) || s_tlast;

    assign rdy_o    = !out_valid_reg || m_tready;
    assign rdy5     = !s5_valid_reg || rdy_o;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;

    always_comb begin
        phase_t                  ph;
        logic [1:0]              tl;
        logic [23:0]             mt;
        logic [ACC_W-1:0]        acc;
        logic                    neg;
        logic                    seen;
        logic signed [VAL_W-1:0] fday, fyear, fhour, fmin, fsec;
        status_t                 err;
        logic                    again;
        logic [ACC_W+3:0]        acc10;
        logic signed [VAL_W-1:0] val;
        ph    = phase_reg;
        tl    = tlen_reg;
        mt    = mtext_reg;
        acc   = acc_reg;
        neg   = neg_reg;
        seen  = seen_reg;
        fday  = day_reg;
        fyear = year_reg;
        fhour = hour_reg;
        fmin  = min_reg;
        fsec  = sec_reg;
        err   = err_reg;
        again = 1'b0;
        acc10 = '0;
        val   = '0;
        if (s_tdata != 8'd0) begin
            for (int step_i = 0; step_i < 2; step_i++) begin
                if ((step_i == 0) || again) begin
                    again = 1'b0;
                    unique case (ph)
                        PH_WDAY: begin
                            if (is_ws(s_tdata)) begin
                                if (tl != 2'd0) begin
                                    err = ST_FORMAT;
                                    ph  = PH_ERROR;
                                end
                            end else begin
                                tl = tl + 2'd1;
                                if (tl == 2'd3) begin
                                    ph = PH_COMMA;
                                end
                            end
                        end
                        PH_COMMA: begin
                            if (s_tdata == CH_COMMA) begin
                                ph   = PH_MDAY;
                                acc  = '0;
                                neg  = 1'b0;
                                seen = 1'b0;
                                tl   = 2'd0;
                            end else begin
                                err = ST_FORMAT;
                                ph  = PH_ERROR;
                            end
                        end
                        PH_COLON1, PH_COLON2: begin
                            if (s_tdata == CH_COLON) begin
                                ph   = (ph == PH_COLON1) ? PH_MIN : PH_SEC;
                                acc  = '0;
                                neg  = 1'b0;
                                seen = 1'b0;
                                tl   = 2'd0;
                            end else begin
                                err = ST_FORMAT;
                                ph  = PH_ERROR;
                            end
                        end
                        PH_MONTH: begin
                            if (is_ws(s_tdata)) begin
                                if (tl != 2'd0) begin
                                    ph   = PH_YEAR;
                                    acc  = '0;
                                    neg  = 1'b0;
                                    seen = 1'b0;
                                    tl   = 2'd0;
                                end
                            end else begin
                                mt = {mt[15:0], s_tdata};
                                tl = tl + 2'd1;
                                if (tl == 2'd3) begin
                                    ph   = PH_YEAR;
                                    acc  = '0;
                                    neg  = 1'b0;
                                    seen = 1'b0;
                                    tl   = 2'd0;
                                end
                            end
                        end
                        PH_MDAY, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC: begin
                            if ((s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE)) begin
                                seen  = 1'b1;
                                acc10 = ({4'b0000, acc} * (ACC_W + 4)'(10))
                                      + {{ACC_W{1'b0}}, s_tdata[3:0]};
                                acc   = acc10[ACC_W-1:0];
                                if (acc10 > NUM_LIMIT) begin
                                    err = ST_OVERFLOW;
                                    ph  = PH_ERROR;
                                end
                            end else if (seen) begin
                                val = $signed({1'b0, acc});
                                if (neg) begin
                                    val = -val;
                                end
                                unique case (ph)
                                    PH_MDAY: begin
                                        fday = val;
                                        ph   = PH_MONTH;
                                        tl   = 2'd0;
                                        mt   = '0;
                                    end
                                    PH_YEAR: begin
                                        fyear = val;
                                        ph    = PH_HOUR;
                                        acc   = '0;
                                        neg   = 1'b0;
                                        seen  = 1'b0;
                                        tl    = 2'd0;
                                    end
                                    PH_HOUR: begin
                                        fhour = val;
                                        ph    = PH_COLON1;
                                    end
                                    PH_MIN: begin
                                        fmin = val;
                                        ph   = PH_COLON2;
                                    end
                                    default: begin
                                        fsec = val;
                                        ph   = PH_DONE;
                                    end
                                endcase
                                again = (ph != PH_DONE);
                            end else if ((tl == 2'd0) && is_ws(s_tdata)) begin
                                tl = 2'd0;
                            end else if ((tl == 2'd0)
                                         && ((s_tdata == CH_PLUS) || (s_tdata == CH_MINUS))) begin
                                tl  = 2'd1;
                                neg = (s_tdata == CH_MINUS);
                            end else begin
                                err = ST_FORMAT;
                                ph  = PH_ERROR;
                            end
                        end
                        default: begin
                            ph = ph;
                        end
                    endcase
                end
            end
        end
        cons_phase = ph;
        cons_tlen  = tl;
        cons_mtext = mt;
        cons_acc   = acc;
        cons_neg   = neg;
        cons_seen  = seen;
        cons_day   = fday;
        cons_year  = fyear;
        cons_hour  = fhour;
        cons_min   = fmin;
        cons_sec   = fsec;
        cons_err   = err;
    end

    always_comb begin
        phase_t                  ph;
        logic                    hit;
        logic signed [VAL_W-1:0] val;
        ph      = cons_phase;
        fin_sec = cons_sec;
        val     = $signed({1'b0, cons_acc});
        if (cons_neg) begin
            val = -val;
        end
        if ((cons_phase == PH_SEC) && cons_seen) begin
            fin_sec = val;
            ph      = PH_DONE;
        end
        hit     = 1'b0;
        fin_mon = 4'd0;
        for (int i = 0; i < 12; i++) begin
            if (!hit && (cons_mtext == MONTH_NAMES[i])) begin
                hit     = 1'b1;
                fin_mon = 4'(i);
            end
        end
        if (ph == PH_ERROR) begin
            fin_status = cons_err;
        end else if (ph != PH_DONE) begin
            fin_status = ST_FORMAT;
        end else if (!hit) begin
            fin_status = ST_MONTH;
        end else if (cons_year < EPOCH_YEAR) begin
            fin_status = ST_YEAR;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        tlen_next  = tlen_reg;
        mtext_next = mtext_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        day_next   = day_reg;
        year_next  = year_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        err_next   = err_reg;
        if (in_fire) begin
            if (is_end) begin
                phase_next = PH_WDAY;
                tlen_next  = 2'd0;
                mtext_next = '0;
                acc_next   = '0;
                neg_next   = 1'b0;
                seen_next  = 1'b0;
                day_next   = '0;
                year_next  = '0;
                hour_next  = '0;
                min_next   = '0;
                sec_next   = '0;
                err_next   = ST_OK;
            end else begin
                phase_next = cons_phase;
                tlen_next  = cons_tlen;
                mtext_next = cons_mtext;
                acc_next   = cons_acc;
                neg_next   = cons_neg;
                seen_next  = cons_seen;
                day_next   = cons_day;
                year_next  = cons_year;
                hour_next  = cons_hour;
                min_next   = cons_min;
                sec_next   = cons_sec;
                err_next   = cons_err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WDAY;
            tlen_reg  <= 2'd0;
            mtext_reg <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            day_reg   <= '0;
            year_reg  <= '0;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            err_reg   <= ST_OK;
        end else begin
            phase_reg <= phase_next;
            tlen_reg  <= tlen_next;
            mtext_reg <= mtext_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            day_reg   <= day_next;
            year_reg  <= year_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            err_reg   <= err_next;
        end
    end

    // The year is split as (year - 1) = 100 * q + r by a reciprocal product.
    assign n1    = s1_year_reg - ACC_W'(1);
    assign prod1 = {{K_SH{1'b0}}, n1} * {{ACC_W{1'b0}}, RECIP_100};

    assign qx100 = {{(ACC_W - Q_W){1'b0}}, s2_q0_reg} * ACC_W'(100);
    assign rdiff = s2_n_reg - qx100;
    assign r0    = rdiff[7:0];

    always_comb begin
        q3 = s2_q0_reg;
        r3 = r0;
        if (r0 >= 8'd100) begin
            q3 = s2_q0_reg + Q_W'(1);
            r3 = r0 - 8'd100;
        end
        leap3 = (s2_n_reg[1:0] == 2'b11) && ((r3 != 8'd99) || (q3[1:0] == 2'b11));
    end

    assign days4 = (DAYS_W'(365) * ({{(DAYS_W - ACC_W){1'b0}}, s3_n_reg} - DAYS_W'(1969)))
                 + {{(DAYS_W - ACC_W + 2){1'b0}}, s3_n_reg[ACC_W-1:2]}
                 - {{(DAYS_W - Q_W){1'b0}}, s3_q_reg}
                 + {{(DAYS_W - Q_W + 2){1'b0}}, s3_q_reg[Q_W-1:2]}
                 - DAYS_W'(477)
                 + {{(DAYS_W - 9){1'b0}}, days_before(s3_leap_reg, s3_mon_reg)}
                 + {{(DAYS_W - VAL_W){s3_day_reg[VAL_W-1]}}, s3_day_reg}
                 - DAYS_W'(1);

    assign dsec5 = {{(SEC_W - DAYS_W){s4_days_reg[DAYS_W-1]}}, s4_days_reg} * SEC_W'(86400);
    assign tsec5 = ({{(SEC_W - VAL_W){s4_hour_reg[VAL_W-1]}}, s4_hour_reg} * SEC_W'(3600))
                 + ({{(SEC_W - VAL_W){s4_min_reg[VAL_W-1]}}, s4_min_reg} * SEC_W'(60))
                 + {{(SEC_W - VAL_W){s4_sec_reg[VAL_W-1]}}, s4_sec_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= in_fire && is_end;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5) begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (rdy_o) begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_status_reg <= fin_status;
            s1_mon_reg    <= fin_mon;
            s1_year_reg   <= cons_year[ACC_W-1:0];
            s1_day_reg    <= cons_day;
            s1_hour_reg   <= cons_hour;
            s1_min_reg    <= cons_min;
            s1_sec_reg    <= fin_sec;
        end
        if (rdy2) begin
            s2_status_reg <= s1_status_reg;
            s2_mon_reg    <= s1_mon_reg;
            s2_n_reg      <= n1;
            s2_q0_reg     <= prod1[K_SH +: Q_W];
            s2_day_reg    <= s1_day_reg;
            s2_hour_reg   <= s1_hour_reg;
            s2_min_reg    <= s1_min_reg;
            s2_sec_reg    <= s1_sec_reg;
        end
        if (rdy3) begin
            s3_status_reg <= s2_status_reg;
            s3_mon_reg    <= s2_mon_reg;
            s3_n_reg      <= s2_n_reg;
            s3_q_reg      <= q3;
            s3_leap_reg   <= leap3;
            s3_day_reg    <= s2_day_reg;
            s3_hour_reg   <= s2_hour_reg;
            s3_min_reg    <= s2_min_reg;
            s3_sec_reg    <= s2_sec_reg;
        end
        if (rdy4) begin
            s4_status_reg <= s3_status_reg;
            s4_days_reg   <= days4;
            s4_hour_reg   <= s3_hour_reg;
            s4_min_reg    <= s3_min_reg;
            s4_sec_reg    <= s3_sec_reg;
        end
        if (rdy5) begin
            s5_status_reg <= s4_status_reg;
            s5_dsec_reg   <= dsec5;
            s5_tsec_reg   <= tsec5;
        end
        if (rdy_o) begin
            out_status_reg <= s5_status_reg;
            out_epoch_reg  <= (s5_status_reg == ST_OK) ? (s5_dsec_reg + s5_tsec_reg) : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_epoch_reg};
    assign m_tuser  = out_status_reg;

    `HDEP_ASSERT_IMPL(a_error_gives_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `HDEP_ASSERT_NEXT(a_end_restarts, aclk, aresetn, s_tvalid && s_tready && is_end, (phase_reg == PH_WDAY) && s1_valid_reg)
    `HDEP_ASSERT_IMPL(a_error_code_in_error_phase, aclk, aresetn, phase_reg != PH_ERROR, err_reg == ST_OK)
    `HDEP_ASSERT_NEXT(a_last_stage_holds, aclk, aresetn, s5_valid_reg && m_tvalid && !m_tready, s5_valid_reg)

endmodule

`default_nettype wire
